FILE: rtl/bcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared constants, register indexes and types of the binary cross
// morphology filter.
// ----------------------------------------------------------------------------
package bcm_pkg;

  // Default sizes of the line memories and the row counter.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Configuration register fields.
  localparam int MODE_W       = 2;
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 13;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 13;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMG_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMG_HEIGHT = 2'd2;

  // Operating modes; any other code passes pixels through.
  localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;

  // Register reset values.
  localparam logic [MODE_W-1:0]       MODE_RST       = MODE_ERODE;
  localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 11'd1024;
  localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 13'd1024;

  // Depth of the output queue.
  localparam int OUT_DEPTH = 4;

  // Position flags of one accepted pixel.
  typedef struct packed {
    logic has_centre;  // a centre pixel of the row above is due
    logic border;      // that centre lies on the image border
    logic self_emit;   // pixel is on the last row and is emitted itself
    logic last_col;    // pixel is the last one of its row
  } pos_t;

  // One result item.
  typedef struct packed {
    logic pix;
    logic last;
  } result_t;

endpackage

FILE: rtl/binary_cross_morphology.sv
`timescale 1ns / 1ps
// An accepted pixel is held in the window stage register, then pushed into the
// output queue once that has room, and is offered on m_axis from the queue.
// Throughput: one input pixel per cycle while the output queue has room;
// last-row pixels yield two results, so there the single output port limits it.
// Reset clears counters and queue and presets configuration; line memories
// need no clearing. Input waits on refetch, set after reset or a register write.
// ----------------------------------------------------------------------------
// binary_cross_morphology
// Streaming 3x3 cross erosion / dilation (or pass-through) of a binary raster
// image, built around two line memories (previous row and row before it).
// ----------------------------------------------------------------------------
module binary_cross_morphology
  import bcm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] pixel_in, [7:1] zero
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [0] pixel_out, [7:1] zero
  output logic                  m_axis_tlast    // frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [MODE_W-1:0]       mode;
  logic [IMG_WIDTH_W-1:0]  img_width;
  logic [IMG_HEIGHT_W-1:0] img_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_RST;
      img_width  <= IMG_WIDTH_RST;
      img_height <= IMG_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODE:       mode       <= cfg_data[MODE_W-1:0];
        CFG_IMG_WIDTH:  img_width  <= cfg_data[IMG_WIDTH_W-1:0];
        CFG_IMG_HEIGHT: img_height <= cfg_data[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // A size change can move the current column, so the prefetched line
  // memory words are stale after reset or a register write.
  logic refetch;

  always_ff @(posedge clk) begin
    if (rst) begin
      refetch <= 1'b1;
    end else begin
      refetch <= cfg_we;
    end
  end

  logic          accept;
  logic          px;
  logic [CW-1:0] col;
  logic [CW-1:0] rd_addr;
  pos_t          pos;

  assign px     = s_axis_tdata[0];
  assign accept = s_axis_tvalid && s_axis_tready;

  // Raster position tracking.
  bcm_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .img_width  (img_width),
    .img_height (img_height),
    .col        (col),
    .rd_addr    (rd_addr),
    .pos        (pos)
  );

  // Line memories. Both are read one column ahead; the current column is
  // written back at each transaction (previous row moves to the older one).
  logic prev_ram_q;
  logic old_ram_q;
  logic prev_rd;
  logic old_rd;
  logic fwd;
  logic fwd_px;
  logic fwd_centre;

  bcm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_prev_row (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (px),
    .raddr (rd_addr),
    .rdata (prev_ram_q)
  );

  bcm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_older_row (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (prev_rd),
    .raddr (rd_addr),
    .rdata (old_ram_q)
  );

  // Forwarding for a one-pixel row, where the prefetch hits the entry just
  // written in the same transaction.
  assign prev_rd = fwd ? fwd_px : prev_ram_q;
  assign old_rd  = fwd ? fwd_centre : old_ram_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= accept && (rd_addr == col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_px     <= px;
      fwd_centre <= prev_rd;
    end
  end

  // Window stage: centre, up and left are captured at the transaction; the
  // right neighbor is the prefetched previous-row entry.
  logic    s1_valid;
  pos_t    s1_pos;
  logic    s1_px;
  logic    s1_centre;
  logic    s1_up;
  logic    s1_left;
  logic    left_q;
  logic    room;
  logic    push_go;
  logic    centre_res;
  logic [1:0] push_cnt;
  result_t res_centre;
  result_t res_self;
  result_t push_d0;
  result_t out_data;

  assign push_go       = s1_valid && room;
  assign s_axis_tready = (!s1_valid || push_go) && !refetch;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos    <= pos;
      s1_px     <= px;
      s1_centre <= prev_rd;
      s1_up     <= old_rd;
      s1_left   <= left_q;
      left_q    <= prev_rd;
    end
  end

  // Cross operator on the centre pixel.
  always_comb begin
    centre_res = s1_centre;
    if (!s1_pos.border) begin
      unique case (mode)
        MODE_ERODE:  centre_res = s1_centre & s1_up & s1_left & prev_rd & s1_px;
        MODE_DILATE: centre_res = s1_centre | s1_up | s1_left | prev_rd | s1_px;
        default:     centre_res = s1_centre;
      endcase
    end
  end

  // Results of the pixel: the centre above if due, then itself on the last row.
  always_comb begin
    res_centre.pix  = centre_res;
    res_centre.last = 1'b0;
    res_self.pix    = s1_px;
    res_self.last   = s1_pos.last_col;
    push_d0         = s1_pos.has_centre ? res_centre : res_self;
    if (push_go) begin
      push_cnt = {1'b0, s1_pos.has_centre} + {1'b0, s1_pos.self_emit};
    end else begin
      push_cnt = 2'd0;
    end
  end

  bcm_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push_d0   (push_d0),
    .push_d1   (res_self),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {7'd0, out_data.pix};
  assign m_axis_tlast = out_data.last;

endmodule

FILE: rtl/bcm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_ram
// Generic simple dual-port RAM with one write port and one registered read
// port. A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bcm_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_scan
// Raster position tracker: column and row counters with size clamping,
// position flags of the pixel being accepted, and the line memory read
// address (prefetch of the next pixel's column).
// ----------------------------------------------------------------------------
module bcm_scan
  import bcm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [IMG_WIDTH_W-1:0]       img_width,
  input  logic [IMG_HEIGHT_W-1:0]      img_height,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output pos_t                         pos
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WSW = (IMG_WIDTH_W > $clog2(MAX_WIDTH + 1)) ?
                       IMG_WIDTH_W : $clog2(MAX_WIDTH + 1);
  localparam int HSW = (IMG_HEIGHT_W > $clog2(MAX_HEIGHT + 1)) ?
                       IMG_HEIGHT_W : $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0]  col_count;
  logic [RW-1:0]  row_count;
  logic [WSW-1:0] w_eff;
  logic [HSW-1:0] h_eff;
  logic           col_wrap;
  logic [CW-1:0]  c;
  logic [HSW-1:0] r_pre;
  logic [RW-1:0]  r;
  logic [WSW-1:0] c_inc;
  logic [HSW-1:0] r_inc;
  logic           at_row_end;
  logic           last_row;
  logic [CW-1:0]  col_next;
  logic [RW-1:0]  row_next;

  // Image size clamped to one up to the memory size (width) and MAX_HEIGHT.
  always_comb begin
    if (img_width == '0) begin
      w_eff = WSW'(1);
    end else if (WSW'(img_width) > WSW'(MAX_WIDTH)) begin
      w_eff = WSW'(MAX_WIDTH);
    end else begin
      w_eff = WSW'(img_width);
    end
    if (img_height == '0) begin
      h_eff = HSW'(1);
    end else if (HSW'(img_height) > HSW'(MAX_HEIGHT)) begin
      h_eff = HSW'(MAX_HEIGHT);
    end else begin
      h_eff = HSW'(img_height);
    end
  end

  // Position of the pixel now offered; counters beyond a shrunk size wrap.
  always_comb begin
    col_wrap = WSW'(col_count) >= w_eff;
    c        = col_wrap ? '0 : col_count;
    r_pre    = col_wrap ? HSW'(row_count) + HSW'(1) : HSW'(row_count);
    r        = (r_pre >= h_eff) ? '0 : r_pre[RW-1:0];
  end

  // Position of the pixel after it.
  always_comb begin
    c_inc      = WSW'(c) + WSW'(1);
    r_inc      = HSW'(r) + HSW'(1);
    at_row_end = c_inc >= w_eff;
    last_row   = r_inc == h_eff;
    if (at_row_end) begin
      col_next = '0;
      row_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end else begin
      col_next = c_inc[CW-1:0];
      row_next = r;
    end
  end

  // Flags of the pixel being accepted.
  always_comb begin
    pos.has_centre = r != '0;
    pos.border     = (r == RW'(1)) || (c == '0) || at_row_end;
    pos.self_emit  = last_row;
    pos.last_col   = at_row_end;
  end

  assign col     = c;
  assign rd_addr = accept ? col_next : c;

  // Counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

endmodule

FILE: rtl/bcm_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_out_queue
// Small output queue that takes up to two results per cycle and hands out
// one per transaction on the output stream.
// ----------------------------------------------------------------------------
module bcm_out_queue
  import bcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_cnt,
  input  result_t    push_d0,
  input  result_t    push_d1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data
);

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int NW = $clog2(OUT_DEPTH + 1);

  result_t       mem [OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          pop;

  assign room      = count <= NW'(OUT_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push_d1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_cnt);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + NW'(push_cnt) - NW'(pop);
    end
  end

endmodule
